/* rtl/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and command structs of the sha-1 digest core
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned Rounds      = 80;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned RoundW      = $clog2(Rounds);
  localparam int unsigned CntW        = $clog2(BlockWords);
  localparam int unsigned IdxW        = 3;
  localparam int unsigned LenW        = 64;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Iv [DigestWords] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam word_t PadMark = 32'h8000_0000;

  // word pushed into the block window
  typedef enum logic [2:0] {
    PushData,
    PushMark,
    PushZero,
    PushLenHi,
    PushLenLo
  } push_sel_e;

  // round function group, twenty rounds each
  typedef enum logic [1:0] {
    StageCh,
    StageParA,
    StageMaj,
    StageParB
  } stage_e;

  function automatic word_t round_k(stage_e stage);
    word_t k;
    case (stage)
      StageCh:   k = 32'h5A82_7999;
      StageParA: k = 32'h6ED9_EBA1;
      StageMaj:  k = 32'h8F1B_BCDC;
      default:   k = 32'hCA62_C1D6;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic            push;
    push_sel_e       push_sel;
    logic            len_add;
    logic            load_work;
    logic            round_en;
    stage_e          stage;
    logic            chain_add;
    logic            clear;
    logic [IdxW-1:0] out_sel;
  } cmd_t;

  typedef struct packed {
    logic cnt_is_14;
    logic cnt_is_15;
  } sts_t;

endpackage

/* rtl/sha1_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer: word intake, padding, round count and digest output
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_last_i,
  input  logic                    in_full_word_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_last_o,
  input  sha1_pkg::sts_t          sts_i,
  output sha1_pkg::cmd_t          cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [sha1_pkg::RoundW-1:0] LastRound = sha1_pkg::RoundW'(sha1_pkg::Rounds - 1);
  localparam logic [sha1_pkg::IdxW-1:0]   LastIdx   =
    sha1_pkg::IdxW'(sha1_pkg::DigestWords - 1);

  logic [2:0]                   state_q, state_d;
  logic [2:0]                   ret_q, ret_d;
  logic [sha1_pkg::RoundW-1:0]  round_q, round_d;
  logic [sha1_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                         mark_q, mark_d;
  logic                         lenhi_q, lenhi_d;
  sha1_pkg::push_sel_e          pad_sel;

  always_comb begin
    if (mark_q) begin
      pad_sel = sha1_pkg::PushMark;
    end else if (lenhi_q) begin
      pad_sel = sha1_pkg::PushLenLo;
    end else if (sts_i.cnt_is_14) begin
      pad_sel = sha1_pkg::PushLenHi;
    end else begin
      pad_sel = sha1_pkg::PushZero;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    round_d     = round_q;
    idx_d       = idx_q;
    mark_d      = mark_q;
    lenhi_d     = lenhi_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.push_sel = sha1_pkg::PushData;
    cmd_o.out_sel  = idx_q;
    if (round_q < sha1_pkg::RoundW'(20)) begin
      cmd_o.stage = sha1_pkg::StageCh;
    end else if (round_q < sha1_pkg::RoundW'(40)) begin
      cmd_o.stage = sha1_pkg::StageParA;
    end else if (round_q < sha1_pkg::RoundW'(60)) begin
      cmd_o.stage = sha1_pkg::StageMaj;
    end else begin
      cmd_o.stage = sha1_pkg::StageParB;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.push    = 1'b1;
          cmd_o.len_add = 1'b1;
          mark_d        = in_last_i & in_full_word_i;
          lenhi_d       = 1'b0;
          if (in_last_i) begin
            state_d = S_PAD;
          end
          if (sts_i.cnt_is_15) begin
            cmd_o.load_work = 1'b1;
            round_d         = '0;
            ret_d           = in_last_i ? S_PAD : S_IDLE;
            state_d         = S_ROUND;
          end
        end
      end
      S_PAD: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = pad_sel;
        if (pad_sel == sha1_pkg::PushMark) begin
          mark_d = 1'b0;
        end
        if (pad_sel == sha1_pkg::PushLenHi) begin
          lenhi_d = 1'b1;
        end
        if (sts_i.cnt_is_15) begin
          cmd_o.load_work = 1'b1;
          round_d         = '0;
          ret_d           = (pad_sel == sha1_pkg::PushLenLo) ? S_OUT : S_PAD;
          state_d         = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 1'b1;
        if (round_q == LastRound) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.chain_add = 1'b1;
        idx_d           = '0;
        state_d         = ret_q;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == LastIdx) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_last_o = (idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      round_q <= '0;
      idx_q   <= '0;
      mark_q  <= 1'b0;
      lenhi_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      mark_q  <= mark_d;
      lenhi_q <= lenhi_d;
    end
  end

endmodule

/* rtl/sha1_dp.sv */
// ----------------------------------------------------------------------------
// sha1_dp
// datapath: message window, round unit, chaining value and bit length
// ----------------------------------------------------------------------------
module sha1_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sha1_pkg::cmd_t              cmd_i,
  output sha1_pkg::sts_t              sts_o,
  input  sha1_pkg::word_t             data_word_i,
  input  logic [2:0]                  byte_count_i,
  input  logic                        message_end_i,
  output sha1_pkg::word_t             digest_word_o
);

  sha1_pkg::word_t              w_q [sha1_pkg::BlockWords];
  sha1_pkg::word_t              chain_q [sha1_pkg::DigestWords];
  sha1_pkg::word_t              a_q, b_q, c_q, d_q, e_q;
  logic [sha1_pkg::CntW-1:0]    cnt_q;
  logic [sha1_pkg::LenW-1:0]    len_q;

  logic [2:0]       sat_count;
  logic [5:0]       len_step;
  sha1_pkg::word_t  keep, mark, last_word, push_word, shift_in, sched, f, t;

  // valid bytes of a partial last word, and the marker just after them
  always_comb begin
    sat_count = byte_count_i[2] ? 3'd4 : byte_count_i;
    case (byte_count_i[1:0])
      2'd0:    begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
      2'd1:    begin keep = 32'hFF00_0000; mark = 32'h0080_0000; end
      2'd2:    begin keep = 32'hFFFF_0000; mark = 32'h0000_8000; end
      default: begin keep = 32'hFFFF_FF00; mark = 32'h0000_0080; end
    endcase
    last_word = byte_count_i[2] ? data_word_i : ((data_word_i & keep) | mark);
    len_step  = message_end_i ? {sat_count, 3'b000} : 6'd32;
  end

  always_comb begin
    case (cmd_i.push_sel)
      sha1_pkg::PushData:  push_word = message_end_i ? last_word : data_word_i;
      sha1_pkg::PushMark:  push_word = sha1_pkg::PadMark;
      sha1_pkg::PushLenHi: push_word = len_q[63:32];
      sha1_pkg::PushLenLo: push_word = len_q[31:0];
      default:             push_word = '0;
    endcase
  end

  // schedule word sixteen rounds ahead of the one in use
  assign sched = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                  w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign shift_in = cmd_i.round_en ? sched : push_word;

  always_comb begin
    case (cmd_i.stage)
      sha1_pkg::StageCh:  f = (b_q & c_q) | (~b_q & d_q);
      sha1_pkg::StageMaj: f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:            f = b_q ^ c_q ^ d_q;
    endcase
    t = {a_q[26:0], a_q[31:27]} + f + e_q + sha1_pkg::round_k(cmd_i.stage) + w_q[0];
  end

  assign sts_o.cnt_is_14 = (cnt_q == sha1_pkg::CntW'(14));
  assign sts_o.cnt_is_15 = (cnt_q == sha1_pkg::CntW'(15));

  assign digest_word_o = chain_q[cmd_i.out_sel];

  // window shifts on every pushed word and on every round
  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round_en) begin
      for (int i = 0; i < sha1_pkg::BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[sha1_pkg::BlockWords-1] <= shift_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round_en) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
        chain_q[i] <= sha1_pkg::Iv[i];
      end
      cnt_q <= '0;
      len_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
          chain_q[i] <= sha1_pkg::Iv[i];
        end
        len_q <= '0;
        cnt_q <= '0;
      end else begin
        if (cmd_i.chain_add) begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
        end
        if (cmd_i.len_add) begin
          len_q <= len_q + sha1_pkg::LenW'(len_step);
        end
        if (cmd_i.push) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/sha1_message_digest_core.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// sha-1 digest over a stream of big-endian 32-bit message words
// ----------------------------------------------------------------------------
// intake: a word beat is taken whenever the core is idle; each full 16-word block then
//   holds the input while its rounds and the chain update run,
//   since all rounds run on the single shared round unit
// after the last word: padding pushes 2 to 18 words (one per cycle between rounds),
//   one or two blocks are hashed, then five digest beats, one per cycle while ready
// reset: asynchronous active-low, chaining value back to the initial hash
module sha1_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // message words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] data_word, [34:32] byte_count, zero fill
  input  logic        s_axis_tlast_i,   // message_end
  // digest words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast_o    // digest_last
);

  sha1_pkg::cmd_t  cmd;
  sha1_pkg::sts_t  sts;
  sha1_pkg::word_t digest_word;

  // sequencer: decides what gets pushed into the window and when rounds run
  sha1_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_last_i      (s_axis_tlast_i),
    .in_full_word_i (s_axis_tdata_i[34]),   // byte_count of four or more
    .in_ready_o     (s_axis_tready_o),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_last_o     (m_axis_tlast_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // window, round unit and chaining value
  sha1_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_word_i    (s_axis_tdata_i[31:0]),
    .byte_count_i   (s_axis_tdata_i[34:32]),
    .message_end_i  (s_axis_tlast_i),
    .digest_word_o  (digest_word)
  );

  // digest beat straight from the chain registers, held until taken
  assign m_axis_tdata_o = {5'b00000, cmd.out_sel, digest_word};

endmodule
